// ===== design/rgcq_pkg.sv =====
`default_nettype none
package rgcq_pkg;

  localparam int NumSteps = 8;

  localparam logic [2:0] MASK_POWER    = 3'b001;
  localparam logic [2:0] MASK_VELOCITY = 3'b010;
  localparam logic [2:0] MASK_WIDTH    = 3'b100;
  localparam logic [7:0] CODE_MAX      = 8'hFF;

  localparam logic [2:0] REG_MIN_POWER    = 3'd0;
  localparam logic [2:0] REG_POWER_MAX    = 3'd1;
  localparam logic [2:0] REG_VELOCITY_MAX = 3'd2;
  localparam logic [2:0] REG_WIDTH_MAX    = 3'd3;
  localparam logic [2:0] REG_FIELD_MASK   = 3'd4;

  // One quantizer lane: partial remainder x (< 2*den unless saturated), quotient so far.
  typedef struct packed {
    logic        active;
    logic        sat;
    logic [24:0] x;
    logic [7:0]  q;
  } lane_t;

  typedef struct packed {
    logic  stored;
    logic  gmark;
    lane_t pw;
    lane_t vel;
    lane_t wid;
  } item_t;

  typedef struct packed {
    logic [22:0] power_max;
    logic [22:0] velocity_max;
    logic [22:0] width_max;
  } dens_t;

  function automatic logic [7:0] lane_code(input lane_t l);
    logic [7:0] c;
    if (l.sat) c = CODE_MAX;
    else if (l.active) c = l.q;
    else c = 8'd0;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/rgcq_step.sv =====
`default_nettype none
module rgcq_step
  import rgcq_pkg::*;
(
  input  item_t item_i,
  input  dens_t dens_i,
  output item_t item_o
);

  function automatic lane_t one_bit(input lane_t l, input logic [22:0] den);
    lane_t       r;
    logic        b;
    logic [24:0] xs;
    r  = l;
    b  = (l.x >= {2'b00, den});
    xs = b ? (l.x - {2'b00, den}) : l.x;
    r.x = {xs[23:0], 1'b0};
    r.q = {l.q[6:0], b};
    return r;
  endfunction

  always_comb begin
    item_o     = item_i;
    item_o.pw  = one_bit(item_i.pw,  dens_i.power_max);
    item_o.vel = one_bit(item_i.vel, dens_i.velocity_max);
    item_o.wid = one_bit(item_i.wid, dens_i.width_max);
  end

endmodule
`default_nettype wire

// ===== design/range_gate_compress_quantize_top.sv =====
`default_nettype none
// Range gate compressor / quantizer.
// Input channel (in_*): one range gate per item, taken when in_valid is high
// and in_stall is low. Result channel (out_*): exactly one result item per
// input item, in order, taken when out_valid is high and out_stall is low.
// Configuration (cfg_*): write cfg_wdata to register cfg_index when cfg_we is
// high; only while no item is in flight.
// Path: the prepare register loads the item at the accepting edge, then eight
// division stages follow, one quotient bit per stage for all three lanes;
// out_valid rises once the item reaches the last stage.
// Throughput: one item per cycle unless in_stall is high; the eight-stage
// bit-serial divider is fully pipelined.
// Stall: each stage holds while its successor is full and stalled; bubbles
// collapse, so the input keeps taking items until every stage is full.
// Reset (rst_n low, synchronous): pipeline emptied, registers return to
// min_power 768, power_max 15360, velocity_max 256000, width_max 256000,
// field_mask 7.
module range_gate_compress_quantize_top
  import rgcq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_ground_scatter,
  input  wire logic        in_quality_ok,
  input  wire logic [23:0] in_lag_zero_power,
  input  wire logic [23:0] in_lag_power,
  input  wire logic [23:0] in_doppler_velocity,
  input  wire logic [23:0] in_spectral_width,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_gate_stored,
  output      logic        out_ground_mark,
  output      logic [7:0]  out_power_code,
  output      logic [7:0]  out_velocity_code,
  output      logic [7:0]  out_width_code,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  // config registers
  logic [23:0] min_power_r;
  logic [22:0] power_max_r, velocity_max_r, width_max_r;
  logic [2:0]  field_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_power_r    <= 24'd768;
      power_max_r    <= 23'd15360;
      velocity_max_r <= 23'd256000;
      width_max_r    <= 23'd256000;
      field_mask_r   <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_POWER:    min_power_r    <= cfg_wdata;
        REG_POWER_MAX:    power_max_r    <= cfg_wdata[22:0];
        REG_VELOCITY_MAX: velocity_max_r <= cfg_wdata[22:0];
        REG_WIDTH_MAX:    width_max_r    <= cfg_wdata[22:0];
        REG_FIELD_MASK:   field_mask_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  dens_t dens;
  assign dens = '{power_max: power_max_r, velocity_max: velocity_max_r,
                  width_max: width_max_r};

  // prepare stage: threshold, numerators, saturation and zero detection.
  // Each lane divides x0 (< 2*den) to 8 bits: code = floor(x0*128/den).
  item_t       prep_nxt;
  logic        stored;
  logic signed [25:0] vnum;

  always_comb begin
    stored = in_quality_ok && ($signed(in_lag_zero_power) > $signed(min_power_r));
    vnum   = $signed({3'b000, velocity_max_r}) +
             $signed({{2{in_doppler_velocity[23]}}, in_doppler_velocity});

    prep_nxt        = '0;
    prep_nxt.stored = stored;
    prep_nxt.gmark  = in_ground_scatter;

    // power: x0 = 2*p, saturate when p >= den
    prep_nxt.pw.active = stored && (field_mask_r & MASK_POWER) != 3'd0 &&
                         $signed(in_lag_power) > 24'sd0;
    prep_nxt.pw.sat    = prep_nxt.pw.active &&
                         ({1'b0, in_lag_power[22:0]} >= {1'b0, power_max_r});
    prep_nxt.pw.x      = prep_nxt.pw.active ? {in_lag_power, 1'b0} : 25'd0;

    // velocity: x0 = vmax + v, saturate when x0 >= 2*den
    prep_nxt.vel.active = stored && (field_mask_r & MASK_VELOCITY) != 3'd0 &&
                          vnum > 26'sd0;
    prep_nxt.vel.sat    = prep_nxt.vel.active &&
                          (vnum[24:0] >= {1'b0, velocity_max_r, 1'b0});
    prep_nxt.vel.x      = prep_nxt.vel.active ? vnum[24:0] : 25'd0;

    // width: same as power
    prep_nxt.wid.active = stored && (field_mask_r & MASK_WIDTH) != 3'd0 &&
                          $signed(in_spectral_width) > 24'sd0;
    prep_nxt.wid.sat    = prep_nxt.wid.active &&
                          ({1'b0, in_spectral_width[22:0]} >= {1'b0, width_max_r});
    prep_nxt.wid.x      = prep_nxt.wid.active ? {in_spectral_width, 1'b0} : 25'd0;
  end

  // stage 0 = prepared item, stage k = k quotient bits done
  item_t                st_r   [NumSteps+1];
  item_t                st_nxt [NumSteps+1];
  logic [NumSteps:0]    vld_r;
  logic [NumSteps+1:0]  rdy;

  assign st_nxt[0] = prep_nxt;

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    rgcq_step u_step (
      .item_i (st_r[k]),
      .dens_i (dens),
      .item_o (st_nxt[k+1])
    );
  end

  always_comb begin
    rdy[NumSteps+1] = !out_stall;
    for (int k = NumSteps; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k <= NumSteps; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NumSteps; k++) begin
      if (rdy[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign out_valid         = vld_r[NumSteps];
  assign out_gate_stored   = st_r[NumSteps].stored;
  assign out_ground_mark   = st_r[NumSteps].gmark;
  assign out_power_code    = lane_code(st_r[NumSteps].pw);
  assign out_velocity_code = lane_code(st_r[NumSteps].vel);
  assign out_width_code    = lane_code(st_r[NumSteps].wid);

`ifndef NO_ASSERTIONS
  // an unstored gate never carries a code
  a_unstored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_gate_stored |->
      out_power_code == 8'd0 && out_velocity_code == 8'd0 && out_width_code == 8'd0)
    else $error("unstored gate with nonzero code");

  // input backs up only when the whole pipe is full behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && (&vld_r))
    else $error("input stalled with room in the pipeline");

  // a held result does not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_code) &&
      $stable(out_velocity_code) && $stable(out_width_code))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_range_gate_compress_quantize_top.sv =====
`default_nettype none
module tb_range_gate_compress_quantize_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rgcq_pkg::*;

  localparam int GateCount = 800;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic        ground_scatter;
    logic        quality_ok;
    logic [23:0] lag_zero_power;
    logic [23:0] lag_power;
    logic [23:0] doppler_velocity;
    logic [23:0] spectral_width;
  } gate_t;

  typedef struct {
    logic       gate_stored;
    logic       ground_mark;
    logic [7:0] power_code;
    logic [7:0] velocity_code;
    logic [7:0] width_code;
  } codes_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_ground_scatter;
  logic in_quality_ok;
  logic [23:0] in_lag_zero_power;
  logic [23:0] in_lag_power;
  logic [23:0] in_doppler_velocity;
  logic [23:0] in_spectral_width;
  logic out_valid;
  logic out_stall;
  logic out_gate_stored;
  logic out_ground_mark;
  logic [7:0] out_power_code;
  logic [7:0] out_velocity_code;
  logic [7:0] out_width_code;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;

  range_gate_compress_quantize_top i_dut (.*);

  // bench copy of the register file
  logic signed [23:0] min_power_q;
  logic [22:0] power_max_q;
  logic [22:0] velocity_max_q;
  logic [22:0] width_max_q;
  logic [2:0]  field_mask_q;

  gate_t  pending_gates[$];
  codes_t expected_codes[$];

  int  error_count = 0;
  int  gates_sent = 0;
  int  codes_seen = 0;
  int  stored_seen = 0;
  int  cycle_count = 0;
  bit  idle_enable = 0;   // random bubbles/stalls on both sides
  bit  hold_output = 0;   // long receiver hold-off
  int  hold_left = 0;
  bit  in_taken = 0;      // item accepted at the last rising edge

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // trunc(num*scale/den), saturated to 0..255; zero full scale saturates by sign
  function automatic logic [7:0] quantize_code(longint num, longint scale, longint den);
    longint q;
    if (num <= 0) return 8'd0;
    if (den == 0) return CODE_MAX;
    q = (num * scale) / den;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic codes_t compress_gate(gate_t g);
    codes_t c;
    longint p0, pl, v, wl;
    p0 = longint'($signed(g.lag_zero_power));
    pl = longint'($signed(g.lag_power));
    v  = longint'($signed(g.doppler_velocity));
    wl = longint'($signed(g.spectral_width));
    c.gate_stored = g.quality_ok && (p0 > longint'(min_power_q));
    c.ground_mark = g.ground_scatter;
    c.power_code = 0;
    c.velocity_code = 0;
    c.width_code = 0;
    if (c.gate_stored) begin
      if (field_mask_q & MASK_POWER)
        c.power_code = quantize_code(pl, 256, longint'(power_max_q));
      if (field_mask_q & MASK_VELOCITY)
        c.velocity_code = quantize_code(longint'(velocity_max_q) + v, 128,
                                        longint'(velocity_max_q));
      if (field_mask_q & MASK_WIDTH)
        c.width_code = quantize_code(wl, 256, longint'(width_max_q));
    end
    return c;
  endfunction

  // register write at a rising edge, driven from the falling edge
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_MIN_POWER:    min_power_q = val;
      REG_POWER_MAX:    power_max_q = val[22:0];
      REG_VELOCITY_MAX: velocity_max_q = val[22:0];
      REG_WIDTH_MAX:    width_max_q = val[22:0];
      REG_FIELD_MASK:   field_mask_q = val[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_gates.size() == 0 && !in_valid && expected_codes.size() == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_field(int mode);
    case (mode)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return $urandom;
      default: return 24'($urandom_range(0, 6000)) - 24'd500;
    endcase
  endfunction

  task automatic push_random_gate();
    gate_t g;
    g.ground_scatter = $urandom_range(0, 1);
    g.quality_ok = ($urandom_range(0, 9) != 0);
    // mostly passing power so the quantizers get exercised
    g.lag_zero_power = ($urandom_range(0, 3) == 0) ? rand_field($urandom_range(0, 3))
                     : min_power_q + 24'($urandom_range(1, 3000));
    g.lag_power = ($urandom_range(0, 4) == 0) ? rand_field($urandom_range(0, 2))
                : 24'($urandom_range(0, 2 * power_max_q + 2)) - 24'd100;
    g.doppler_velocity = ($urandom_range(0, 4) == 0) ? rand_field($urandom_range(0, 2))
                       : 24'($urandom_range(0, 2 * velocity_max_q + 2)) - 24'(velocity_max_q);
    g.spectral_width = ($urandom_range(0, 4) == 0) ? rand_field($urandom_range(0, 2))
                     : 24'($urandom_range(0, 2 * width_max_q + 2)) - 24'd100;
    pending_gates.push_back(g);
  endtask

  task automatic push_gate(logic gs, logic qok, logic [23:0] p0, logic [23:0] pl,
                           logic [23:0] v, logic [23:0] w);
    gate_t g;
    g.ground_scatter = gs;
    g.quality_ok = qok;
    g.lag_zero_power = p0;
    g.lag_power = pl;
    g.doppler_velocity = v;
    g.spectral_width = w;
    pending_gates.push_back(g);
  endtask

  // driver: payload held while stalled, new item or bubble after each acceptance
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_gates.size() > 0 && !(idle_enable && $urandom_range(0, 99) < 15)) begin
          gate_t g;
          g = pending_gates.pop_front();
          in_valid <= 1;
          in_ground_scatter <= g.ground_scatter;
          in_quality_ok <= g.quality_ok;
          in_lag_zero_power <= g.lag_zero_power;
          in_lag_power <= g.lag_power;
          in_doppler_velocity <= g.doppler_velocity;
          in_spectral_width <= g.spectral_width;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall: long hold-off counted here, otherwise random
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_output && hold_left == 0) hold_left = 300;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        if (hold_left == 0) hold_output = 0;
        out_stall <= 1;
      end else begin
        out_stall <= idle_enable && ($urandom_range(0, 99) < 15);
      end
    end
  end

  // input acceptance: predict with the registers current at this edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      gate_t g;
      g.ground_scatter = in_ground_scatter;
      g.quality_ok = in_quality_ok;
      g.lag_zero_power = in_lag_zero_power;
      g.lag_power = in_lag_power;
      g.doppler_velocity = in_doppler_velocity;
      g.spectral_width = in_spectral_width;
      expected_codes.push_back(compress_gate(g));
      gates_sent++;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      codes_t e;
      codes_seen++;
      if (out_gate_stored) stored_seen++;
      if (expected_codes.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        e = expected_codes.pop_front();
        if (out_gate_stored !== e.gate_stored) begin
          $error("gate_stored exp %0d got %0d", e.gate_stored, out_gate_stored);
          error_count++;
        end
        if (out_ground_mark !== e.ground_mark) begin
          $error("ground_mark exp %0d got %0d", e.ground_mark, out_ground_mark);
          error_count++;
        end
        if (out_power_code !== e.power_code) begin
          $error("power_code exp %0d got %0d", e.power_code, out_power_code);
          error_count++;
        end
        if (out_velocity_code !== e.velocity_code) begin
          $error("velocity_code exp %0d got %0d", e.velocity_code, out_velocity_code);
          error_count++;
        end
        if (out_width_code !== e.width_code) begin
          $error("width_code exp %0d got %0d", e.width_code, out_width_code);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_ground_scatter = 0;
    in_quality_ok = 0;
    in_lag_zero_power = 0;
    in_lag_power = 0;
    in_doppler_velocity = 0;
    in_spectral_width = 0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = REG_MIN_POWER;
    cfg_wdata = 0;
    min_power_q = 24'sd768;
    power_max_q = 23'd15360;
    velocity_max_q = 23'd256000;
    width_max_q = 23'd256000;
    field_mask_q = 3'd7;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // directed: reset settings, extremes, threshold edge, saturation
    push_gate(0, 1, 24'd769, 24'd15360, 24'd0, 24'd128000);
    push_gate(1, 1, 24'd768, 24'd100, 24'd100, 24'd100);        // at threshold: not stored
    push_gate(1, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF); // quality off
    push_gate(0, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF); // saturate
    push_gate(1, 1, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000); // negatives
    push_gate(0, 1, 24'h800000, 24'd500, 24'd0, 24'd500);        // min lag-zero power
    push_gate(0, 1, 24'd1000, 24'd15359, -24'd256000, 24'd255999);
    push_gate(1, 1, 24'd1000, 24'd59, 24'd255999, 24'd999);
    push_gate(0, 1, 24'd1000, 24'd60, -24'd255999, 24'd1000);
    wait_drained();

    // extreme register settings, one phase each
    write_reg(REG_MIN_POWER, 24'h800000);
    write_reg(REG_POWER_MAX, 24'd1);
    write_reg(REG_VELOCITY_MAX, 24'd1);
    write_reg(REG_WIDTH_MAX, 24'd1);
    write_reg(REG_FIELD_MASK, 24'd5);
    push_gate(1, 1, 24'h800001, 24'd1, 24'd0, 24'd1);
    push_gate(0, 1, 24'h800000, 24'd1, 24'd0, 24'd1);
    push_gate(1, 1, 24'd0, 24'd0, -24'd1, 24'd0);
    wait_drained();
    write_reg(REG_MIN_POWER, 24'h7FFFFF);
    write_reg(REG_POWER_MAX, 24'h7FFFFF);
    write_reg(REG_VELOCITY_MAX, 24'h7FFFFF);
    write_reg(REG_WIDTH_MAX, 24'h7FFFFF);
    write_reg(REG_FIELD_MASK, 24'd2);
    push_gate(1, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF); // never stored
    wait_drained();
    write_reg(REG_MIN_POWER, 24'h800000);
    push_gate(0, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    push_gate(1, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    wait_drained();

    // random phases with mid-range settings; each phase ends drained
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MIN_POWER, 24'($urandom_range(0, 4000)) - 24'd2000);
      write_reg(REG_POWER_MAX, 24'($urandom_range(1, 40000)));
      write_reg(REG_VELOCITY_MAX, 24'($urandom_range(1, 300000)));
      write_reg(REG_WIDTH_MAX, 24'($urandom_range(1, 300000)));
      write_reg(REG_FIELD_MASK, (ph == 0) ? 24'd0 : (ph == 1) ? 24'd7 : 24'($urandom_range(0, 7)));
      idle_enable = (ph != 2);  // one phase runs with no bubbles or stalls
      if (ph == 4) hold_output = 1; // long output hold-off fills the pipe
      for (int n = 0; n < GateCount / 8; n++) push_random_gate();
      if (ph == 5) begin
        // sender pauses until everything is back, then resumes
        wait (pending_gates.size() == 0 && !in_valid && expected_codes.size() == 0);
        for (int n = 0; n < 20; n++) push_random_gate();
      end
      wait_drained();
    end

    $display("sent %0d gates, checked %0d results (%0d stored) over 12 register settings",
             gates_sent, codes_seen, stored_seen);
    if (error_count == 0 && expected_codes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
